// ----- hw/rtl/fmdp_pkg.sv -----
// Shared types, codes and constants of the FM register dump parser.
package fmdp_pkg;

	localparam int POSITION_BITS_DEFAULT = 32;

	// Input command codes.
	localparam logic [1:0] CMD_DATA  = 2'd0;
	localparam logic [1:0] CMD_END   = 2'd1;
	localparam logic [1:0] CMD_START = 2'd2;

	// Event kinds.
	localparam logic [2:0] KIND_FRAMES   = 3'd0;
	localparam logic [2:0] KIND_CHIP     = 3'd1;
	localparam logic [2:0] KIND_LOOP     = 3'd2;
	localparam logic [2:0] KIND_REG      = 3'd3;
	localparam logic [2:0] KIND_FINISHED = 3'd4;
	localparam logic [2:0] KIND_FAILED   = 3'd5;

	// Error codes.
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_SIGNATURE = 2'd1;
	localparam logic [1:0] ERR_EARLY_END = 2'd2;
	localparam logic [1:0] ERR_FEW_FRAMES = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_FRAME_FLOOR  = 2'd0;
	localparam logic [1:0] REG_MAX_NAME     = 2'd1;
	localparam logic [1:0] REG_MAX_COMMENT  = 2'd2;

	localparam logic [15:0] FRAME_FLOOR_RESET = 16'd150;
	localparam logic [9:0]  MAX_NAME_RESET    = 10'd64;
	localparam logic [9:0]  MAX_COMMENT_RESET = 10'd384;

	// Command stream opcodes.
	localparam logic [7:0] OP_FRAME  = 8'hff;
	localparam logic [7:0] OP_SKIP   = 8'hfe;
	localparam logic [7:0] OP_CHIP1  = 8'hfd;
	localparam logic [7:0] OP_CHIP0  = 8'hfc;
	localparam logic [7:0] OP_FINISH = 8'hfb;
	localparam logic [7:0] OP_LOOP   = 8'hfa;

	localparam logic [8:0] SKIP_BASE = 9'd3;

	// Signature "TFMD".
	localparam logic [7:0] SIG_BYTES [4] = '{8'h54, 8'h46, 8'h4d, 8'h44};

	typedef enum logic [3:0] {
		PH_SIG      = 4'd0,
		PH_TITLE    = 4'd1,
		PH_AUTHOR   = 4'd2,
		PH_COMMENT  = 4'd3,
		PH_CMD      = 4'd4,
		PH_SKIP_ARG = 4'd5,
		PH_REG_VAL  = 4'd6,
		PH_DONE     = 4'd7
	} phase_t;

	typedef struct packed {
		logic [15:0] frame_floor;
		logic [9:0]  max_name_length;
		logic [9:0]  max_comment_length;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [9:0]  field_counter;
		logic [7:0]  pending_index;
		logic [11:0] header_end;
		logic [31:0] frame_total;
	} ctx_t;

	localparam ctx_t CTX_RESET = '{
		phase: PH_SIG,
		field_counter: 10'd0,
		pending_index: 8'd0,
		header_end: 12'd0,
		frame_total: 32'd0
	};

	typedef struct packed {
		logic [2:0]  kind;
		logic [8:0]  frame_count;
		logic        chip;
		logic [7:0]  reg_index;
		logic [7:0]  reg_value;
		logic [1:0]  error_code;
		logic [31:0] total_frames;
		logic [11:0] header_length;
		logic [31:0] used_length;
	} result_t;

endpackage

// ----- hw/rtl/fmdp_in_if.sv -----
// Input channel: one dump word (command and data byte) per handshake.
interface fmdp_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] data_byte;

	modport source (output valid, output cmd, output data_byte, input ready);
	modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

// ----- hw/rtl/fmdp_out_if.sv -----
// Output channel: one parser event per handshake.
interface fmdp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [8:0]  frame_count;
	logic        chip;
	logic [7:0]  reg_index;
	logic [7:0]  reg_value;
	logic [1:0]  error_code;
	logic [31:0] total_frames;
	logic [11:0] header_length;
	logic [31:0] used_length;

	modport source (output valid, output kind, output frame_count, output chip,
		output reg_index, output reg_value, output error_code, output total_frames,
		output header_length, output used_length, input ready);
	modport sink (input valid, input kind, input frame_count, input chip,
		input reg_index, input reg_value, input error_code, input total_frames,
		input header_length, input used_length, output ready);
endinterface

// ----- hw/rtl/fm_register_dump_parser.sv -----
// Top level of the FM register dump parser: word register, parser state, event register.
//
// The parser takes a register dump one word at a time on in_ch. Each word carries
// a command (data byte, end of data, start new dump) and a data byte. Parsed
// events leave on out_ch: frames begun, chip select, loop marker, register write,
// finished or failed. Words that complete no event produce nothing on out_ch.
// The three limits (minimum frame count, name length, comment length) are written by the user
// through cfg_we, cfg_index and cfg_data only while the parser is idle; the block does not enforce it.
//
// An accepted word is captured in an input register and decoded against the parser
// state; an event it causes is then captured in the event register, which drives
// out_ch.
// One word is taken every cycle as long as the event register is empty or being
// drained, so the sustained rate is one word per cycle.
// When the receiver stalls with an event pending, the input register holds one
// more word and then in_ch.ready drops until the event is taken.
//
// Reset clears the parser to the start of a dump (expecting the signature) and
// restores the limits to their defaults; both registers come up empty.
module fm_register_dump_parser #(
	parameter int POSITION_BITS = fmdp_pkg::POSITION_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	fmdp_in_if.sink     in_ch,
	fmdp_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	fmdp_pkg::cfg_t    cfg_q;
	fmdp_pkg::ctx_t    ctx_q;
	fmdp_pkg::ctx_t    ctx_nxt;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] pos_nxt;

	logic              valid_s1;
	logic [1:0]        cmd_s1;
	logic [7:0]        byte_s1;

	logic              out_valid_q;
	fmdp_pkg::result_t out_q;
	fmdp_pkg::result_t res;
	logic              res_valid;

	// The decode stage moves whenever the event register can take a new event.
	logic advance;
	assign advance     = !out_valid_q || out_ch.ready;
	assign in_ch.ready = !valid_s1 || advance;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_floor        <= fmdp_pkg::FRAME_FLOOR_RESET;
			cfg_q.max_name_length    <= fmdp_pkg::MAX_NAME_RESET;
			cfg_q.max_comment_length <= fmdp_pkg::MAX_COMMENT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				fmdp_pkg::REG_FRAME_FLOOR: cfg_q.frame_floor        <= cfg_data;
				fmdp_pkg::REG_MAX_NAME:    cfg_q.max_name_length    <= cfg_data[9:0];
				fmdp_pkg::REG_MAX_COMMENT: cfg_q.max_comment_length <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	// Input word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			cmd_s1  <= in_ch.cmd;
			byte_s1 <= in_ch.data_byte;
		end
	end

	fmdp_step #(
		.POSITION_BITS(POSITION_BITS)
	) u_step (
		.cfg       (cfg_q),
		.ctx       (ctx_q),
		.pos       (pos_q),
		.cmd       (cmd_s1),
		.data_byte (byte_s1),
		.ctx_nxt   (ctx_nxt),
		.pos_nxt   (pos_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	// Parser state advances once per decoded word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= fmdp_pkg::CTX_RESET;
			pos_q <= '0;
		end else if (valid_s1 && advance) begin
			ctx_q <= ctx_nxt;
			pos_q <= pos_nxt;
		end
	end

	// Event register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid) begin
			out_q <= res;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.kind          = out_q.kind;
	assign out_ch.frame_count   = out_q.frame_count;
	assign out_ch.chip          = out_q.chip;
	assign out_ch.reg_index     = out_q.reg_index;
	assign out_ch.reg_value     = out_q.reg_value;
	assign out_ch.error_code    = out_q.error_code;
	assign out_ch.total_frames  = out_q.total_frames;
	assign out_ch.header_length = out_q.header_length;
	assign out_ch.used_length   = out_q.used_length;

endmodule

// ----- hw/rtl/fmdp_step.sv -----
// Next-state and event logic for one dump word.
module fmdp_step #(
	parameter int POSITION_BITS = fmdp_pkg::POSITION_BITS_DEFAULT
) (
	input  fmdp_pkg::cfg_t             cfg,
	input  fmdp_pkg::ctx_t             ctx,
	input  logic [POSITION_BITS-1:0]   pos,
	input  logic [1:0]                 cmd,
	input  logic [7:0]                 data_byte,
	output fmdp_pkg::ctx_t             ctx_nxt,
	output logic [POSITION_BITS-1:0]   pos_nxt,
	output logic                       res_valid,
	output fmdp_pkg::result_t          res
);

	always_comb begin
		fmdp_pkg::phase_t          ph;
		logic [9:0]                fc;
		logic [9:0]                lim;
		logic [11:0]               hend;
		logic [POSITION_BITS-1:0]  pos_inc;
		logic [63:0]               pos_wide;
		logic [31:0]               addend;
		logic [32:0]               sum;
		logic [31:0]               ft_sat;

		ctx_nxt   = ctx;
		pos_nxt   = pos;
		res_valid = 1'b0;
		res       = '0;

		ph   = ctx.phase;
		fc   = ctx.field_counter;
		hend = ctx.header_end;
		pos_inc = (pos == '1) ? pos : pos + 1'b1;
		pos_wide = 64'(pos_inc);

		// Strings already at their limit end before this byte is consumed.
		for (int i = 0; i < 3; i++) begin
			lim = (ph == fmdp_pkg::PH_COMMENT) ? cfg.max_comment_length
				: cfg.max_name_length;
			if ((ph == fmdp_pkg::PH_TITLE || ph == fmdp_pkg::PH_AUTHOR ||
					ph == fmdp_pkg::PH_COMMENT) && fc >= lim) begin
				ph = fmdp_pkg::phase_t'(4'(ph) + 4'd1);
				fc = '0;
				if (ph == fmdp_pkg::PH_CMD) begin
					hend = pos[11:0];
				end
			end
		end

		addend = (ph == fmdp_pkg::PH_SKIP_ARG) ? 32'(fmdp_pkg::SKIP_BASE + 9'(data_byte))
			: 32'd1;
		sum    = {1'b0, ctx.frame_total} + {1'b0, addend};
		ft_sat = sum[32] ? '1 : sum[31:0];

		case (cmd)
			fmdp_pkg::CMD_START: begin
				ctx_nxt = fmdp_pkg::CTX_RESET;
				pos_nxt = '0;
			end
			fmdp_pkg::CMD_END: begin
				if (ctx.phase != fmdp_pkg::PH_DONE) begin
					res_valid        = 1'b1;
					res.kind         = fmdp_pkg::KIND_FAILED;
					res.error_code   = (ctx.phase == fmdp_pkg::PH_SIG)
						? fmdp_pkg::ERR_SIGNATURE : fmdp_pkg::ERR_EARLY_END;
					res.total_frames = ctx.frame_total;
					ctx_nxt.phase    = fmdp_pkg::PH_DONE;
				end
			end
			fmdp_pkg::CMD_DATA: begin
				if (ctx.phase != fmdp_pkg::PH_DONE) begin
					ctx_nxt.phase         = ph;
					ctx_nxt.field_counter = fc;
					ctx_nxt.header_end    = hend;
					pos_nxt               = pos_inc;
					case (ph)
						fmdp_pkg::PH_SIG: begin
							if (data_byte != fmdp_pkg::SIG_BYTES[fc[1:0]]) begin
								res_valid        = 1'b1;
								res.kind         = fmdp_pkg::KIND_FAILED;
								res.error_code   = fmdp_pkg::ERR_SIGNATURE;
								res.total_frames = ctx.frame_total;
								ctx_nxt.phase    = fmdp_pkg::PH_DONE;
							end else if (fc >= 10'd3) begin
								ctx_nxt.phase         = fmdp_pkg::PH_TITLE;
								ctx_nxt.field_counter = '0;
							end else begin
								ctx_nxt.field_counter = fc + 10'd1;
							end
						end
						fmdp_pkg::PH_TITLE, fmdp_pkg::PH_AUTHOR, fmdp_pkg::PH_COMMENT: begin
							if (data_byte == 8'd0) begin
								ctx_nxt.phase         = fmdp_pkg::phase_t'(4'(ph) + 4'd1);
								ctx_nxt.field_counter = '0;
								if (ph == fmdp_pkg::PH_COMMENT) begin
									ctx_nxt.header_end = pos_inc[11:0];
								end
							end else begin
								ctx_nxt.field_counter = fc + 10'd1;
							end
						end
						fmdp_pkg::PH_SKIP_ARG: begin
							ctx_nxt.frame_total = ft_sat;
							ctx_nxt.phase       = fmdp_pkg::PH_CMD;
							res_valid           = 1'b1;
							res.kind            = fmdp_pkg::KIND_FRAMES;
							res.frame_count     = fmdp_pkg::SKIP_BASE + 9'(data_byte);
						end
						fmdp_pkg::PH_REG_VAL: begin
							ctx_nxt.phase = fmdp_pkg::PH_CMD;
							res_valid     = 1'b1;
							res.kind      = fmdp_pkg::KIND_REG;
							res.reg_index = ctx.pending_index;
							res.reg_value = data_byte;
						end
						fmdp_pkg::PH_CMD: begin
							case (data_byte)
								fmdp_pkg::OP_FINISH: begin
									res_valid        = 1'b1;
									res.total_frames = ctx.frame_total;
									ctx_nxt.phase    = fmdp_pkg::PH_DONE;
									if (ctx.frame_total < {16'd0, cfg.frame_floor}) begin
										res.kind       = fmdp_pkg::KIND_FAILED;
										res.error_code = fmdp_pkg::ERR_FEW_FRAMES;
									end else begin
										res.kind          = fmdp_pkg::KIND_FINISHED;
										res.header_length = hend;
										res.used_length   = (pos_wide[63:32] != 32'd0)
											? '1 : pos_wide[31:0];
									end
								end
								fmdp_pkg::OP_FRAME: begin
									ctx_nxt.frame_total = ft_sat;
									res_valid           = 1'b1;
									res.kind            = fmdp_pkg::KIND_FRAMES;
									res.frame_count     = 9'd1;
								end
								fmdp_pkg::OP_SKIP: begin
									ctx_nxt.phase = fmdp_pkg::PH_SKIP_ARG;
								end
								fmdp_pkg::OP_CHIP1: begin
									res_valid = 1'b1;
									res.kind  = fmdp_pkg::KIND_CHIP;
									res.chip  = 1'b1;
								end
								fmdp_pkg::OP_CHIP0: begin
									res_valid = 1'b1;
									res.kind  = fmdp_pkg::KIND_CHIP;
								end
								fmdp_pkg::OP_LOOP: begin
									res_valid = 1'b1;
									res.kind  = fmdp_pkg::KIND_LOOP;
								end
								default: begin
									ctx_nxt.pending_index = data_byte;
									ctx_nxt.phase         = fmdp_pkg::PH_REG_VAL;
								end
							endcase
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- test/fm_register_dump_parser_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the FM register dump parser: directed dumps, then random dumps.
module fm_register_dump_parser_tb;

	import fmdp_pkg::*;

	localparam int CLK_PERIOD    = 8;
	// Cycles to let pass after the last expected event before touching the settings.
	// An event leaves the event register after its word is decoded, so this covers words in flight.
	localparam int SETTLE_CYCLES = 6;
	// Length of the long receiver hold-off that makes the parser back up into its input.
	localparam int LONG_HOLD     = 200;
	localparam int CYCLE_LIMIT   = 400000;
	// Counted words per random settings phase.
	localparam int PHASE_WORDS   = 190;
	// The fourth command value has no meaning and must be ignored.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data;
	} dump_word_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	fmdp_in_if  in_if ();
	fmdp_out_if out_if ();

	fm_register_dump_parser u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_if),
		.out_ch   (out_if),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Words waiting for the driver, and the events the parser still owes us.
	dump_word_t words_to_send [$];
	result_t    events_due [$];

	// Handshake flags sampled at the rising edge and used at the next falling edge.
	logic word_taken  = 1'b0;
	logic event_taken = 1'b0;

	int  events_seen = 0;
	int  mismatches  = 0;
	int  phase_items = 0;
	int  send_wait   = 0;
	int  hold_left   = 0;
	// When set, neither side draws idle gaps, which gives stretches of full-rate traffic.
	bit  calm        = 1'b0;

	// Our own copy of the parser settings and state.
	logic [15:0] cfg_frame_floor = FRAME_FLOOR_RESET;
	logic [9:0]  cfg_name_max    = MAX_NAME_RESET;
	logic [9:0]  cfg_comment_max = MAX_COMMENT_RESET;

	phase_t      dump_phase   = PH_SIG;
	logic [9:0]  str_count    = '0;
	logic [7:0]  held_index   = '0;
	logic [31:0] byte_pos     = '0;
	logic [11:0] header_len   = '0;
	logic [31:0] frames_total = '0;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Moves on to the next header field. Leaving the comment marks the end of the
	// header, and its length is taken from the byte position at that moment.
	function automatic void next_field();
		dump_phase = phase_t'(dump_phase + 4'd1);
		str_count  = '0;
		if (dump_phase == PH_CMD)
			header_len = byte_pos[11:0];
	endfunction

	// The frame total sticks at its maximum instead of wrapping.
	function automatic void add_frames(input logic [31:0] n);
		logic [32:0] sum;
		sum = {1'b0, frames_total} + {1'b0, n};
		frames_total = sum[32] ? '1 : sum[31:0];
	endfunction

	// A failed event closes the dump until the next start.
	function automatic void give_up(inout result_t ev, input logic [1:0] code);
		ev.kind         = KIND_FAILED;
		ev.error_code   = code;
		ev.total_frames = frames_total;
		dump_phase      = PH_DONE;
	endfunction

	// Applies one dump word to our state and tells whether it completes an event.
	function automatic bit parse_word(input logic [1:0] cmd, input logic [7:0] b,
			output result_t ev);
		ev = '0;
		if (cmd == CMD_START) begin
			dump_phase   = PH_SIG;
			str_count    = '0;
			held_index   = '0;
			byte_pos     = '0;
			header_len   = '0;
			frames_total = '0;
			return 1'b0;
		end
		if ((cmd != CMD_DATA && cmd != CMD_END) || dump_phase == PH_DONE)
			return 1'b0;
		if (cmd == CMD_END) begin
			give_up(ev, (dump_phase == PH_SIG) ? ERR_SIGNATURE : ERR_EARLY_END);
			return 1'b1;
		end

		// A string that already holds its limit ends without a terminator, so this
		// byte belongs to whatever follows. A zero limit skips the string outright.
		while (dump_phase >= PH_TITLE && dump_phase <= PH_COMMENT &&
				str_count >= ((dump_phase == PH_COMMENT) ? cfg_comment_max : cfg_name_max))
			next_field();

		if (byte_pos != '1)
			byte_pos = byte_pos + 32'd1;

		case (dump_phase)
			PH_SIG: begin
				if (b != SIG_BYTES[str_count[1:0]]) begin
					give_up(ev, ERR_SIGNATURE);
					return 1'b1;
				end
				str_count = str_count + 10'd1;
				if (str_count >= 10'd4) begin
					dump_phase = PH_TITLE;
					str_count  = '0;
				end
				return 1'b0;
			end
			PH_TITLE, PH_AUTHOR, PH_COMMENT: begin
				if (b == 8'd0)
					next_field();
				else
					str_count = str_count + 10'd1;
				return 1'b0;
			end
			PH_SKIP_ARG: begin
				add_frames(32'd3 + {24'd0, b});
				dump_phase     = PH_CMD;
				ev.kind        = KIND_FRAMES;
				ev.frame_count = SKIP_BASE + {1'b0, b};
				return 1'b1;
			end
			PH_REG_VAL: begin
				dump_phase   = PH_CMD;
				ev.kind      = KIND_REG;
				ev.reg_index = held_index;
				ev.reg_value = b;
				return 1'b1;
			end
			default: ;
		endcase

		// Command stream.
		case (b)
			OP_FINISH: begin
				if (frames_total < {16'd0, cfg_frame_floor}) begin
					give_up(ev, ERR_FEW_FRAMES);
					return 1'b1;
				end
				ev.kind          = KIND_FINISHED;
				ev.total_frames  = frames_total;
				ev.header_length = header_len;
				ev.used_length   = byte_pos;
				dump_phase       = PH_DONE;
				return 1'b1;
			end
			OP_FRAME: begin
				add_frames(32'd1);
				ev.kind        = KIND_FRAMES;
				ev.frame_count = 9'd1;
				return 1'b1;
			end
			OP_SKIP: begin
				dump_phase = PH_SKIP_ARG;
				return 1'b0;
			end
			OP_CHIP1: begin
				ev.kind = KIND_CHIP;
				ev.chip = 1'b1;
				return 1'b1;
			end
			OP_CHIP0: begin
				ev.kind = KIND_CHIP;
				ev.chip = 1'b0;
				return 1'b1;
			end
			OP_LOOP: begin
				ev.kind = KIND_LOOP;
				return 1'b1;
			end
			default: begin
				held_index = b;
				dump_phase = PH_REG_VAL;
				return 1'b0;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch in %s of event %0d: expected %0h, got %0h",
					what, events_seen, want, got);
		end
	endtask

	// Monitor: at each rising edge, a word taken by the parser goes through the
	// predictor, and an event handed out is compared with the oldest expectation.
	always @(posedge clk) begin
		result_t ev;
		result_t due;
		bit      took_word;
		bit      took_event;
		took_word  = arst_n && in_if.valid && in_if.ready;
		took_event = arst_n && out_if.valid && out_if.ready;
		word_taken  <= took_word;
		event_taken <= took_event;
		if (took_word && parse_word(in_if.cmd, in_if.data_byte, ev))
			events_due.push_back(ev);
		if (took_event) begin
			events_seen <= events_seen + 1;
			if (events_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected event %0d: kind %0d", events_seen, out_if.kind);
			end else begin
				due = events_due.pop_front();
				check_field("kind", 32'(out_if.kind), 32'(due.kind));
				check_field("frame_count", 32'(out_if.frame_count), 32'(due.frame_count));
				check_field("chip", 32'(out_if.chip), 32'(due.chip));
				check_field("reg_index", 32'(out_if.reg_index), 32'(due.reg_index));
				check_field("reg_value", 32'(out_if.reg_value), 32'(due.reg_value));
				check_field("error_code", 32'(out_if.error_code), 32'(due.error_code));
				check_field("total_frames", out_if.total_frames, due.total_frames);
				check_field("header_length", 32'(out_if.header_length),
					32'(due.header_length));
				check_field("used_length", out_if.used_length, due.used_length);
			end
		end
	end

	// ------------------------------------------------------------------
	// Driver and receiver
	// ------------------------------------------------------------------

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 7);
	endfunction

	// Driver: changes the input at falling edges. A word stays up until the monitor
	// has seen it taken; then the driver either idles for the drawn number of cycles
	// or puts the next word up right away, without lowering valid in between.
	always @(negedge clk) begin
		dump_word_t w;
		if (!in_if.valid || word_taken) begin
			if (send_wait > 0) begin
				send_wait--;
				in_if.valid <= 1'b0;
			end else if (words_to_send.size() != 0) begin
				w = words_to_send.pop_front();
				in_if.valid     <= 1'b1;
				in_if.cmd       <= w.cmd;
				in_if.data_byte <= w.data;
				send_wait = draw_gap();
			end else begin
				in_if.valid <= 1'b0;
			end
		end
	end

	// Receiver: after each event it takes, it holds ready low for a drawn number of
	// cycles. Twice in the run it holds off for a long stretch instead, while the
	// driver keeps offering words, so the parser fills up and stalls its input.
	always @(negedge clk) begin
		if (event_taken) begin
			hold_left = draw_gap();
			if (events_seen == 100 || events_seen == 400)
				hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_if.ready <= 1'b0;
		end else begin
			out_if.ready <= 1'b1;
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		int cycles;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// Queues one word. Unused command words and words sent after the dump is closed
	// do nothing, so they are not counted toward the phase length.
	task automatic push_word(input logic [1:0] c, input logic [7:0] d, input bit live = 1'b1);
		words_to_send.push_back('{cmd: c, data: d});
		if (live && c != CMD_UNUSED)
			phase_items++;
	endtask

	task automatic push_signature();
		for (int i = 0; i < 4; i++)
			push_word(CMD_DATA, SIG_BYTES[i]);
	endtask

	// Signature and the three strings. A string that reaches its limit gets no
	// terminator, since the parser cuts it there and moves on by itself.
	task automatic push_header();
		int cap;
		int len;
		push_signature();
		for (int s = 0; s < 3; s++) begin
			cap = (s == 2) ? int'(cfg_comment_max) : int'(cfg_name_max);
			if (cap <= 8 && $urandom_range(0, 3) == 0)
				len = cap;
			else
				len = $urandom_range(0, (cap < 6) ? cap : 6);
			for (int i = 0; i < len; i++)
				push_word(CMD_DATA, 8'($urandom_range(1, 255)));
			if (len < cap)
				push_word(CMD_DATA, 8'd0);
		end
	endtask

	task automatic push_commands(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 29) == 0)
				push_word(CMD_UNUSED, 8'($urandom));
			r = $urandom_range(0, 99);
			if (r < 25) begin
				push_word(CMD_DATA, OP_FRAME);
			end else if (r < 40) begin
				push_word(CMD_DATA, OP_SKIP);
				push_word(CMD_DATA, 8'($urandom));
			end else if (r < 48) begin
				push_word(CMD_DATA, OP_CHIP1);
			end else if (r < 56) begin
				push_word(CMD_DATA, OP_CHIP0);
			end else if (r < 62) begin
				push_word(CMD_DATA, OP_LOOP);
			end else begin
				push_word(CMD_DATA, 8'($urandom_range(0, 249)));
				push_word(CMD_DATA, 8'($urandom));
			end
		end
	endtask

	// One dump, opened by a start word. Most have a good header and random commands, then a finish,
	// an end of data or nothing; the rest break the signature or feed random bytes after a good signature.
	task automatic gen_dump();
		int mode;
		int n;
		int k;
		int r;
		calm = ($urandom_range(0, 4) == 0);
		push_word(CMD_START, 8'($urandom));
		mode = $urandom_range(0, 9);
		if (mode < 8) begin
			push_header();
			push_commands($urandom_range(0, 24));
			k = $urandom_range(0, 9);
			if (k < 7)
				push_word(CMD_DATA, OP_FINISH);
			else if (k < 9)
				push_word(CMD_END, 8'($urandom));
			else
				return;     // left open: the next start word cuts it off
		end else if (mode == 8) begin
			k = $urandom_range(0, 3);
			for (int i = 0; i < k; i++)
				push_word(CMD_DATA, SIG_BYTES[i]);
			if ($urandom_range(0, 3) == 0)
				push_word(CMD_END, 8'($urandom));
			else
				push_word(CMD_DATA, SIG_BYTES[k] ^ 8'($urandom_range(1, 255)));
		end else begin
			push_signature();
			n = $urandom_range(1, 20);
			for (int i = 0; i < n; i++) begin
				r = $urandom_range(0, 9);
				push_word((r < 8) ? CMD_DATA : (r == 8) ? CMD_END : CMD_UNUSED, 8'($urandom));
			end
			return;
		end
		// The dump is closed now, so trailing data and end words must be ignored.
		if ($urandom_range(0, 2) == 0) begin
			n = $urandom_range(1, 3);
			for (int i = 0; i < n; i++)
				push_word($urandom_range(0, 1) ? CMD_END : CMD_DATA, 8'($urandom), 1'b0);
		end
	endtask

	// Settings are written only while the parser is idle. Our copy changes at once.
	task automatic write_setting(input logic [1:0] idx, input logic [15:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			REG_FRAME_FLOOR: cfg_frame_floor = value;
			REG_MAX_NAME:    cfg_name_max    = value[9:0];
			REG_MAX_COMMENT: cfg_comment_max = value[9:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Holds off new words until everything queued has been taken and every expected
	// event has come back, then lets words without an event drain out of the parser.
	task automatic wait_drained();
		while (words_to_send.size() != 0 || in_if.valid || events_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = REG_FRAME_FLOOR;
		cfg_data        = '0;
		in_if.valid     = 1'b0;
		in_if.cmd       = CMD_DATA;
		in_if.data_byte = '0;
		out_if.ready    = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Reset settings. A complete header with an empty title and comment, every
		// opcode but finish, a skip argument at its maximum and register writes at the
		// lowest and highest index, then end of data in the command stream.
		push_signature();
		push_word(CMD_DATA, 8'd0);
		push_word(CMD_DATA, 8'h78);
		push_word(CMD_DATA, 8'd0);
		push_word(CMD_DATA, 8'd0);
		push_word(CMD_DATA, OP_FRAME);
		push_word(CMD_DATA, OP_SKIP);
		push_word(CMD_DATA, 8'hff);
		push_word(CMD_DATA, OP_CHIP1);
		push_word(CMD_DATA, OP_CHIP0);
		push_word(CMD_DATA, OP_LOOP);
		push_word(CMD_DATA, 8'h00);
		push_word(CMD_DATA, 8'h00);
		push_word(CMD_DATA, 8'hf9);
		push_word(CMD_DATA, 8'hff);
		push_word(CMD_END, 8'h00);
		// Closed dump: these are ignored, as is an unused command word.
		push_word(CMD_END, 8'h00);
		push_word(CMD_DATA, SIG_BYTES[0]);
		push_word(CMD_UNUSED, 8'h5a);
		// Signature mismatch on its last byte, then end of data during the signature.
		push_word(CMD_START, 8'h00);
		push_word(CMD_DATA, SIG_BYTES[0]);
		push_word(CMD_DATA, SIG_BYTES[1]);
		push_word(CMD_DATA, SIG_BYTES[2]);
		push_word(CMD_DATA, 8'h58);
		push_word(CMD_START, 8'h00);
		push_word(CMD_END, 8'h00);
		wait_drained();

		// Zero limits: all three strings take no bytes, and zero frames is enough.
		write_setting(REG_FRAME_FLOOR, 16'd0);
		write_setting(REG_MAX_NAME, 16'd0);
		write_setting(REG_MAX_COMMENT, 16'd0);
		push_word(CMD_START, 8'h00);
		push_signature();
		push_word(CMD_DATA, OP_FINISH);
		wait_drained();

		// Every string cut at its limit with no terminator, and a frame minimum
		// that this dump does not meet.
		write_setting(REG_FRAME_FLOOR, 16'hffff);
		write_setting(REG_MAX_NAME, 16'd1);
		write_setting(REG_MAX_COMMENT, 16'd2);
		push_word(CMD_START, 8'h00);
		push_signature();
		push_word(CMD_DATA, 8'h61);
		push_word(CMD_DATA, 8'h62);
		push_word(CMD_DATA, 8'h63);
		push_word(CMD_DATA, 8'h64);
		push_word(CMD_DATA, OP_FRAME);
		push_word(CMD_DATA, OP_FINISH);
		wait_drained();

		// Random dumps under several settings, the extremes among them.
		for (int p = 0; p < 8; p++) begin
			case (p)
				1: begin
					write_setting(REG_FRAME_FLOOR, 16'hffff);
					write_setting(REG_MAX_NAME, 16'd1023);
					write_setting(REG_MAX_COMMENT, 16'd1023);
				end
				2: begin
					write_setting(REG_FRAME_FLOOR, 16'd0);
					write_setting(REG_MAX_NAME, 16'd1);
					write_setting(REG_MAX_COMMENT, 16'd1);
				end
				default: begin
					write_setting(REG_FRAME_FLOOR, 16'($urandom_range(0, 700)));
					write_setting(REG_MAX_NAME, 16'($urandom_range(1, 10)));
					write_setting(REG_MAX_COMMENT, 16'($urandom_range(1, 16)));
				end
			endcase
			phase_items = 0;
			while (phase_items < PHASE_WORDS)
				gen_dump();
			wait_drained();
		end

		if (mismatches == 0 && events_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/fmdp_pkg.sv
hw/rtl/fmdp_in_if.sv
hw/rtl/fmdp_out_if.sv
hw/rtl/fmdp_step.sv
hw/rtl/fm_register_dump_parser.sv
test/fm_register_dump_parser_tb.sv
